/* design/bms_pkg.sv */
// bms_pkg: shared types and constants for the ball motion step block.
// Holds the payload structs, the control structs between the top level and the
// axis units, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package bms_pkg;

  localparam int unsigned TimeW  = 16;  // tick_time, unsigned Q0.16
  localparam int unsigned WordW  = 32;  // positions, velocities, accelerations
  localparam int unsigned SpeedW = 31;  // friction and speed limits
  localparam int unsigned PixW   = 12;  // radius and arena sizes, whole pixels
  localparam int unsigned FracW  = 16;  // fraction bits of Q16.16
  localparam int unsigned HitW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegFriction = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxSpdX  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxSpdY  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRadius   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWidth    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegHeight   = 3'd5;

  // Reset values
  localparam logic [SpeedW-1:0] FrictionRst = 31'd0;
  localparam logic [SpeedW-1:0] MaxSpdRst   = 31'd65536000;
  localparam logic [PixW-1:0]   RadiusRst   = 12'd10;
  localparam logic [PixW-1:0]   WidthRst    = 12'd800;
  localparam logic [PixW-1:0]   HeightRst   = 12'd600;

  // Wall hit codes
  localparam logic [HitW-1:0] HitNone = 2'd0;
  localparam logic [HitW-1:0] HitFar  = 2'd1;
  localparam logic [HitW-1:0] HitNear = 2'd2;

  typedef struct packed {
    logic        [TimeW-1:0] tick_time;
    logic signed [WordW-1:0] accel_x;
    logic signed [WordW-1:0] accel_y;
  } in_t;

  typedef struct packed {
    logic signed [WordW-1:0] pos_x;
    logic signed [WordW-1:0] pos_y;
    logic signed [WordW-1:0] vel_x;
    logic signed [WordW-1:0] vel_y;
    logic        [HitW-1:0]  hit_x;
    logic        [HitW-1:0]  hit_y;
  } out_t;

  typedef struct packed {
    logic start;  // begin a tick with the operands on the axis inputs
    logic ack;    // result taken, release the axis
  } axis_ctrl_t;

  typedef struct packed {
    logic idle;   // ready for a start
    logic done;   // result held on the axis outputs
  } axis_stat_t;

endpackage

/* design/bms_serial_mul.sv */
// bms_serial_mul: bit-serial shift-add multiplier, signed word times unsigned time.
// Retires one multiplier bit per cycle; product is floor(mcand * mplier / 2^16).
// Depends on bms_pkg.
`timescale 1ns / 1ps

module bms_serial_mul (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load,
  input  logic signed [bms_pkg::WordW-1:0]       mcand,
  input  logic        [bms_pkg::TimeW-1:0]       mplier,
  output logic                                   busy,
  output logic signed [bms_pkg::WordW-1:0]       prod
);

  localparam int unsigned Steps = bms_pkg::TimeW;
  localparam int unsigned CntW  = $clog2(Steps + 1);
  localparam int unsigned HiW   = bms_pkg::WordW + 1;

  logic [CntW-1:0]                  cnt_r, cnt_nxt;
  logic signed [bms_pkg::WordW-1:0] a_r;
  logic signed [HiW-1:0]            hi_r, hi_nxt;
  logic [bms_pkg::TimeW-1:0]        lo_r, lo_nxt;
  logic signed [HiW-1:0]            sum;

  assign busy = (cnt_r != '0);
  assign prod = hi_r[bms_pkg::WordW-1:0];

  always_comb begin
    sum     = hi_r + (lo_r[0] ? {a_r[bms_pkg::WordW-1], a_r} : {HiW{1'b0}});
    hi_nxt  = {sum[HiW-1], sum[HiW-1:1]};
    lo_nxt  = {sum[0], lo_r[bms_pkg::TimeW-1:1]};
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = CntW'(Steps);
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r  <= mcand;
      hi_r <= '0;
      lo_r <= mplier;
    end else if (busy) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

endmodule

/* design/bms_axis.sv */
// bms_axis: one axis of the motion step, velocity update then position update.
// Sequences a bms_serial_mul for both products and holds the axis state.
// Depends on bms_pkg and bms_serial_mul.
`timescale 1ns / 1ps

module bms_axis (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bms_pkg::axis_ctrl_t                   ctrl,
  input  logic signed [bms_pkg::WordW-1:0]      acc,
  input  logic        [bms_pkg::TimeW-1:0]      dt,
  input  logic        [bms_pkg::SpeedW-1:0]     friction,
  input  logic        [bms_pkg::SpeedW-1:0]     vmax,
  input  logic        [bms_pkg::PixW-1:0]       radius,
  input  logic        [bms_pkg::PixW-1:0]       span,
  output bms_pkg::axis_stat_t                   stat,
  output logic signed [bms_pkg::WordW-1:0]      pos,
  output logic signed [bms_pkg::WordW-1:0]      vel,
  output logic        [bms_pkg::HitW-1:0]       hit
);

  localparam int unsigned W  = bms_pkg::WordW;
  localparam int unsigned XW = W + 1;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMulA  = 4'd1;
  localparam logic [3:0] StVSum  = 4'd2;
  localparam logic [3:0] StVFric = 4'd3;
  localparam logic [3:0] StVClmp = 4'd4;
  localparam logic [3:0] StMulV  = 4'd5;
  localparam logic [3:0] StPSum  = 4'd6;
  localparam logic [3:0] StPWall = 4'd7;
  localparam logic [3:0] StDone  = 4'd8;

  logic [3:0]                state_r, state_nxt;
  logic [bms_pkg::TimeW-1:0] dt_r;
  logic signed [W-1:0]       vel_r, vel_nxt;
  logic signed [W-1:0]       pos_r, pos_nxt;
  logic signed [XW-1:0]      cand_r;
  logic [bms_pkg::HitW-1:0]  hit_r, hit_nxt;

  logic                      mul_load, mul_busy;
  logic signed [W-1:0]       mul_mcand, prod;
  logic [bms_pkg::TimeW-1:0] mul_mplier;

  logic signed [XW-1:0]      vsum, vdec, vinc, cand_sum;
  logic signed [W-1:0]       vm, vm_neg, vclamp;
  logic signed [XW-1:0]      r_fix, w_fix, wr_fix;

  bms_serial_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (mul_load),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .busy   (mul_busy),
    .prod   (prod)
  );

  always_comb begin
    // wall limits in Q16.16
    r_fix  = $signed({{(XW-bms_pkg::PixW-bms_pkg::FracW){1'b0}}, radius,
                      {bms_pkg::FracW{1'b0}}});
    w_fix  = $signed({{(XW-bms_pkg::PixW-bms_pkg::FracW){1'b0}}, span,
                      {bms_pkg::FracW{1'b0}}});
    wr_fix = w_fix - r_fix;

    vsum     = {vel_r[W-1], vel_r} + {prod[W-1], prod};
    vdec     = {vel_r[W-1], vel_r} - $signed({2'b00, friction});
    vinc     = {vel_r[W-1], vel_r} + $signed({2'b00, friction});
    vm       = $signed({1'b0, vmax});
    vm_neg   = -vm;
    cand_sum = {pos_r[W-1], pos_r} + {prod[W-1], prod};

    if (vel_r > vm) begin
      vclamp = vm;
    end else if (vel_r < vm_neg) begin
      vclamp = vm_neg;
    end else begin
      vclamp = vel_r;
    end

    state_nxt  = state_r;
    vel_nxt    = vel_r;
    pos_nxt    = pos_r;
    hit_nxt    = hit_r;
    mul_load   = 1'b0;
    mul_mcand  = acc;
    mul_mplier = dt;

    unique case (state_r)
      StIdle: begin
        if (ctrl.start) begin
          mul_load  = 1'b1;
          state_nxt = StMulA;
        end
      end
      StMulA: begin
        if (!mul_busy) begin
          state_nxt = StVSum;
        end
      end
      StVSum: begin
        // saturate velocity plus acceleration times time
        if (vsum[XW-1] != vsum[W-1]) begin
          vel_nxt = vsum[XW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
          vel_nxt = vsum[W-1:0];
        end
        state_nxt = StVFric;
      end
      StVFric: begin
        // pull toward zero without crossing it
        if (vel_r > 0) begin
          vel_nxt = vdec[XW-1] ? '0 : vdec[W-1:0];
        end else if (vel_r < 0) begin
          vel_nxt = vinc[XW-1] ? vinc[W-1:0] : '0;
        end
        state_nxt = StVClmp;
      end
      StVClmp: begin
        vel_nxt    = vclamp;
        mul_load   = 1'b1;
        mul_mcand  = vclamp;
        mul_mplier = dt_r;
        state_nxt  = StMulV;
      end
      StMulV: begin
        if (!mul_busy) begin
          state_nxt = StPSum;
        end
      end
      StPSum: begin
        state_nxt = StPWall;
      end
      StPWall: begin
        // far wall test wins over near wall
        if (cand_r > wr_fix) begin
          pos_nxt = wr_fix[W-1:0];
          hit_nxt = bms_pkg::HitFar;
        end else if (cand_r < r_fix) begin
          pos_nxt = r_fix[W-1:0];
          hit_nxt = bms_pkg::HitNear;
        end else begin
          pos_nxt = cand_r[W-1:0];
          hit_nxt = bms_pkg::HitNone;
        end
        state_nxt = StDone;
      end
      StDone: begin
        if (ctrl.ack) begin
          state_nxt = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      vel_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      vel_r   <= vel_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    if (state_r == StIdle && ctrl.start) begin
      dt_r <= dt;
    end
    if (state_r == StPSum) begin
      cand_r <= cand_sum;
    end
  end

  assign stat.idle = (state_r == StIdle);
  assign stat.done = (state_r == StDone);
  assign pos = pos_r;
  assign vel = vel_r;
  assign hit = hit_r;

endmodule

/* design/ball_motion_step.sv */
// ball_motion_step: top level, configuration registers, input and output stages.
// Runs one bms_axis per axis in lockstep. Depends on bms_pkg, bms_axis.
`timescale 1ns / 1ps

// One input transaction is one animation tick: elapsed time and a 2-D
// acceleration. The block keeps position and velocity per axis in signed Q16.16,
// adds acceleration times time to velocity with saturation, applies friction
// toward zero, clamps to the per-axis speed limit, moves the position by velocity
// times time and pins it against any arena wall the ball's edge would pass,
// flagging the wall. Each tick yields exactly one result transaction. Both
// products of an axis go through one bit-serial multiplier that retires one bit
// of tick_time per cycle; between them come the saturating velocity sum, friction
// and the speed clamp, and after the second the position sum, the wall test and
// the handoff. The next tick is accepted in the cycle after the previous result
// moves into the output register, so a held result only delays the next tick
// once the following result is also finished. Configuration writes are always
// ready and must only be issued while no tick is in flight; indexes above 5 are
// dropped. Reset restores the register defaults and zeroes position and velocity.

module ball_motion_step (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bms_pkg::in_t                       in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output bms_pkg::out_t                      out_data,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bms_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [bms_pkg::CfgDataW-1:0]       cfg_data
);

  logic [bms_pkg::SpeedW-1:0] friction_r, max_spd_x_r, max_spd_y_r;
  logic [bms_pkg::PixW-1:0]   radius_r, width_r, height_r;

  bms_pkg::axis_ctrl_t ctrl;
  bms_pkg::axis_stat_t stat_x, stat_y;

  logic signed [bms_pkg::WordW-1:0] pos_x, pos_y, vel_x, vel_y;
  logic [bms_pkg::HitW-1:0]         hit_x, hit_y;

  logic          in_take, out_load;
  logic          out_valid_r, out_valid_nxt;
  bms_pkg::out_t out_data_r;

  // Configuration: always ready; the user must write only between ticks, the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      friction_r  <= bms_pkg::FrictionRst;
      max_spd_x_r <= bms_pkg::MaxSpdRst;
      max_spd_y_r <= bms_pkg::MaxSpdRst;
      radius_r    <= bms_pkg::RadiusRst;
      width_r     <= bms_pkg::WidthRst;
      height_r    <= bms_pkg::HeightRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bms_pkg::RegFriction: friction_r  <= cfg_data[bms_pkg::SpeedW-1:0];
        bms_pkg::RegMaxSpdX:  max_spd_x_r <= cfg_data[bms_pkg::SpeedW-1:0];
        bms_pkg::RegMaxSpdY:  max_spd_y_r <= cfg_data[bms_pkg::SpeedW-1:0];
        bms_pkg::RegRadius:   radius_r    <= cfg_data[bms_pkg::PixW-1:0];
        bms_pkg::RegWidth:    width_r     <= cfg_data[bms_pkg::PixW-1:0];
        bms_pkg::RegHeight:   height_r    <= cfg_data[bms_pkg::PixW-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Accept a transaction whenever both axes are free; they always run in step.
  assign in_stall = !(stat_x.idle && stat_y.idle);
  assign in_take  = in_valid && !in_stall;

  // Move a finished tick into the output register once it is empty or draining.
  assign out_load = stat_x.done && stat_y.done && (!out_valid_r || !out_stall);

  assign ctrl.start = in_take;
  assign ctrl.ack   = out_load;

  bms_axis u_axis_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .acc      (in_data.accel_x),
    .dt       (in_data.tick_time),
    .friction (friction_r),
    .vmax     (max_spd_x_r),
    .radius   (radius_r),
    .span     (width_r),
    .stat     (stat_x),
    .pos      (pos_x),
    .vel      (vel_x),
    .hit      (hit_x)
  );

  bms_axis u_axis_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .acc      (in_data.accel_y),
    .dt       (in_data.tick_time),
    .friction (friction_r),
    .vmax     (max_spd_y_r),
    .radius   (radius_r),
    .span     (height_r),
    .stat     (stat_y),
    .pos      (pos_y),
    .vel      (vel_y),
    .hit      (hit_y)
  );

  // Output register: hold while stalled, drop valid once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.pos_x <= pos_x;
      out_data_r.pos_y <= pos_y;
      out_data_r.vel_x <= vel_x;
      out_data_r.vel_y <= vel_y;
      out_data_r.hit_x <= hit_x;
      out_data_r.hit_y <= hit_y;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/sv/ball_motion_step_test.sv */
// ball_motion_step_test: self-checking bench for the ball motion step block.
// Predicts every tick's position, velocity and wall flags and compares them
// with the result channel. Depends on bms_pkg and ball_motion_step.
`timescale 1ns / 1ps

module ball_motion_step_test;
  import bms_pkg::*;

  // Around 1010 ticks with stalls on both sides finish far inside this limit,
  // so it only catches a hang.
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned TailCycles   = 50;   // watch for stray results after the drain
  localparam int unsigned ItemsPerRun  = 55;
  localparam int unsigned RunsPerPhase = 6;

  localparam logic signed [WordW-1:0] WordMax  = 32'sh7FFF_FFFF;
  localparam logic signed [WordW-1:0] WordMin  = 32'sh8000_0000;
  localparam logic [TimeW-1:0]        TickMax  = 16'hFFFF;
  localparam logic [SpeedW-1:0]       SpeedTop = 31'h7FFF_FFFF;
  localparam logic [PixW-1:0]         PixTop   = 12'hFFF;
  // Indexes past the last register: the block must drop these writes
  localparam logic [CfgIdxW-1:0]      RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0]      RegSpare7 = 3'd7;
  localparam longint                  OnePixel  = longint'(1) << FracW;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Per-cycle chance, in percent, that the sender pauses or the receiver stalls
  int unsigned send_gap_pct = 8;
  int unsigned recv_stall_pct = 66;

  // Shadow registers, as the block should hold them
  logic [SpeedW-1:0] friction_cfg  = FrictionRst;
  logic [SpeedW-1:0] max_spd_x_cfg = MaxSpdRst;
  logic [SpeedW-1:0] max_spd_y_cfg = MaxSpdRst;
  logic [PixW-1:0]   radius_cfg    = RadiusRst;
  logic [PixW-1:0]   width_cfg     = WidthRst;
  logic [PixW-1:0]   height_cfg    = HeightRst;

  // Predicted ball state, zero after reset
  logic signed [WordW-1:0] ball_pos_x = '0;
  logic signed [WordW-1:0] ball_pos_y = '0;
  logic signed [WordW-1:0] ball_vel_x = '0;
  logic signed [WordW-1:0] ball_vel_y = '0;

  out_t pending_results[$];   // predicted results, oldest first

  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned wall_hits = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  ball_motion_step u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Motion predictor
  // ---------------------------------------------------------------------------

  typedef struct packed {
    logic signed [WordW-1:0] pos;
    logic signed [WordW-1:0] vel;
    logic [HitW-1:0]         hit;
  } axis_move_t;

  function automatic longint clip_word(input longint x);
    if (x > longint'(WordMax)) return longint'(WordMax);
    if (x < longint'(WordMin)) return longint'(WordMin);
    return x;
  endfunction

  // Advance one axis by one tick. Every product is exact in 64 bits and the
  // arithmetic shift gives the floor of the division by 2^16.
  function automatic axis_move_t move_axis_step(
      input logic signed [WordW-1:0] pos,
      input logic signed [WordW-1:0] vel,
      input logic signed [WordW-1:0] acc,
      input logic [TimeW-1:0]        dt,
      input logic [SpeedW-1:0]       vmax,
      input logic [PixW-1:0]         span);
    longint v;
    longint lim;
    longint r;
    longint w;
    longint cand;
    longint pinned;
    axis_move_t res;
    v = clip_word(longint'(vel) + ((longint'(acc) * longint'(dt)) >>> FracW));
    // Friction pulls toward zero but never across it
    if (v > 0) begin
      v = v - longint'(friction_cfg);
      if (v < 0) v = 0;
    end else if (v < 0) begin
      v = v + longint'(friction_cfg);
      if (v > 0) v = 0;
    end
    lim = longint'(vmax);
    if (v > lim) v = lim;
    else if (v < -lim) v = -lim;
    r = longint'(radius_cfg) * OnePixel;
    w = longint'(span) * OnePixel;
    cand = longint'(pos) + ((v * longint'(dt)) >>> FracW);
    // The far wall test wins when a huge radius satisfies both
    res.hit = HitNone;
    if (cand + r > w) begin
      cand = w - r;
      res.hit = HitFar;
    end else if (r - cand > 0) begin
      cand = r;
      res.hit = HitNear;
    end
    pinned = clip_word(cand);
    res.vel = v[WordW-1:0];
    res.pos = pinned[WordW-1:0];
    return res;
  endfunction

  // Advance the predicted ball by one accepted tick and queue its result
  task automatic predict_tick(input in_t t);
    axis_move_t mx;
    axis_move_t my;
    out_t want;
    mx = move_axis_step(ball_pos_x, ball_vel_x, t.accel_x, t.tick_time,
                        max_spd_x_cfg, width_cfg);
    my = move_axis_step(ball_pos_y, ball_vel_y, t.accel_y, t.tick_time,
                        max_spd_y_cfg, height_cfg);
    ball_pos_x = mx.pos;
    ball_vel_x = mx.vel;
    ball_pos_y = my.pos;
    ball_vel_y = my.vel;
    want.pos_x = mx.pos;
    want.pos_y = my.pos;
    want.vel_x = mx.vel;
    want.vel_y = my.vel;
    want.hit_x = mx.hit;
    want.hit_y = my.hit;
    pending_results = {pending_results, want};
    if (mx.hit != HitNone || my.hit != HitNone) wall_hits++;
  endtask

  // ---------------------------------------------------------------------------
  // Channel drivers: drive at the falling edge, sample at the rising edge
  // ---------------------------------------------------------------------------

  // Write one register and mirror it into the shadow copy, masked to its width
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegFriction: friction_cfg  = data[SpeedW-1:0];
      RegMaxSpdX:  max_spd_x_cfg = data[SpeedW-1:0];
      RegMaxSpdY:  max_spd_y_cfg = data[SpeedW-1:0];
      RegRadius:   radius_cfg    = data[PixW-1:0];
      RegWidth:    width_cfg     = data[PixW-1:0];
      RegHeight:   height_cfg    = data[PixW-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send one tick transaction, with a random pause ahead of it. Valid only
  // drops for a pause, so back-to-back ticks keep it high.
  task automatic send_tick(input logic [TimeW-1:0] dt,
                           input logic signed [WordW-1:0] ax,
                           input logic signed [WordW-1:0] ay);
    @(negedge clk);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= '{tick_time: dt, accel_x: ax, accel_y: ay};
    do @(posedge clk); while (in_stall);
    predict_tick(in_data);
    ticks_sent++;
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  function automatic void check_field(input string name,
                                      input logic signed [WordW-1:0] want,
                                      input logic signed [WordW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every accepted result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no tick outstanding: pos_x %0d pos_y %0d",
               out_data.pos_x, out_data.pos_y);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("pos_x", want.pos_x, out_data.pos_x);
        check_field("pos_y", want.pos_y, out_data.pos_y);
        check_field("vel_x", want.vel_x, out_data.vel_x);
        check_field("vel_y", want.vel_y, out_data.vel_y);
        check_field("hit_x", WordW'(want.hit_x), WordW'(out_data.hit_x));
        check_field("hit_y", WordW'(want.hit_y), WordW'(out_data.hit_y));
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [WordW-1:0] q16(input int whole);
    return whole * (1 << FracW);
  endfunction

  // Moderate acceleration, up to 3000 px/s^2 either way
  function automatic logic signed [WordW-1:0] pick_accel();
    return $urandom_range(0, 393216000) - 196608000;
  endfunction

  // Now and then set bits above the register width; the block must mask them
  function automatic logic [CfgDataW-1:0] with_junk(input logic [CfgDataW-1:0] value,
                                                   input int unsigned width);
    logic [CfgDataW-1:0] junk;
    junk = $urandom() << width;
    return ($urandom_range(3) == 0) ? (value | junk) : value;
  endfunction

  // Pick a mostly playable arena, with an occasional extreme
  task automatic apply_random_settings();
    logic [SpeedW-1:0] fric;
    logic [SpeedW-1:0] spd_x;
    logic [SpeedW-1:0] spd_y;
    logic [PixW-1:0]   rad;
    logic [PixW-1:0]   wid;
    logic [PixW-1:0]   hgt;
    case ($urandom_range(9))
      0:       fric = '0;
      1:       fric = SpeedTop;
      default: fric = SpeedW'($urandom_range(0, 60 * 65536));
    endcase
    case ($urandom_range(9))
      0:       spd_x = '0;
      1:       spd_x = SpeedTop;
      default: spd_x = SpeedW'($urandom_range(65536, 2000 * 65536));
    endcase
    case ($urandom_range(9))
      0:       spd_y = SpeedTop;
      1:       spd_y = SpeedW'($urandom());
      default: spd_y = SpeedW'($urandom_range(65536, 2000 * 65536));
    endcase
    case ($urandom_range(9))
      0:       rad = '0;
      1:       rad = PixTop;
      default: rad = PixW'($urandom_range(1, 60));
    endcase
    case ($urandom_range(9))
      0:       wid = PixW'($urandom_range(0, 50));
      1:       wid = PixTop;
      default: wid = PixW'($urandom_range(200, 4095));
    endcase
    case ($urandom_range(9))
      0:       hgt = PixW'($urandom_range(0, 50));
      1:       hgt = PixTop;
      default: hgt = PixW'($urandom_range(200, 4095));
    endcase
    write_reg(RegFriction, with_junk(CfgDataW'(fric), SpeedW));
    write_reg(RegMaxSpdX, with_junk(CfgDataW'(spd_x), SpeedW));
    write_reg(RegMaxSpdY, with_junk(CfgDataW'(spd_y), SpeedW));
    write_reg(RegRadius, with_junk(CfgDataW'(rad), PixW));
    write_reg(RegWidth, with_junk(CfgDataW'(wid), PixW));
    write_reg(RegHeight, with_junk(CfgDataW'(hgt), PixW));
  endtask

  // Mostly frame-rate ticks under a steady push that changes now and then;
  // roughly one tick in seven is raw noise over the full field ranges.
  task automatic run_random_ticks(input int unsigned count);
    logic signed [WordW-1:0] ax;
    logic signed [WordW-1:0] ay;
    logic [TimeW-1:0]        dt;
    ax = pick_accel();
    ay = pick_accel();
    repeat (count) begin
      if ($urandom_range(9) == 0) begin
        ax = pick_accel();
        ay = pick_accel();
      end
      if ($urandom_range(6) == 0) begin
        send_tick(TimeW'($urandom()), $urandom(), $urandom());
      end else begin
        dt = TimeW'($urandom_range(546, 3277));   // 1/120 s to 1/20 s
        send_tick(dt, ax, ay);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: zero tick, full tick with extreme accelerations
  task automatic test_tick_extremes();
    send_tick('0, '0, '0);
    send_tick(TickMax, WordMax, WordMin);
    send_tick(TickMax, WordMin, WordMax);
    send_tick(16'd1, -32'sd1, 32'sd1);
    wait_idle();
  endtask

  // Lift the speed limits so the velocity sum saturates at both ends
  task automatic test_speed_saturation();
    write_reg(RegFriction, '0);
    write_reg(RegMaxSpdX, CfgDataW'(SpeedTop));
    write_reg(RegMaxSpdY, CfgDataW'(SpeedTop));
    write_reg(RegRadius, '0);
    write_reg(RegWidth, CfgDataW'(PixTop));
    write_reg(RegHeight, CfgDataW'(PixTop));
    repeat (3) send_tick(TickMax, WordMax, WordMin);
    send_tick(TickMax, WordMin, WordMax);
    wait_idle();
  endtask

  // Friction that stops the ball without reversing it, then full friction, then zero limits
  task automatic test_friction_and_limits();
    write_reg(RegFriction, q16(50));
    write_reg(RegMaxSpdX, q16(1000));
    write_reg(RegMaxSpdY, q16(1000));
    write_reg(RegRadius, 32'd10);
    write_reg(RegWidth, 32'd800);
    write_reg(RegHeight, 32'd600);
    send_tick(TickMax, q16(100), q16(-100));
    send_tick(TickMax, '0, '0);
    send_tick(TickMax, q16(-30), q16(30));
    wait_idle();
    write_reg(RegFriction, CfgDataW'(SpeedTop));
    send_tick(TickMax, WordMax, WordMin);
    wait_idle();
    write_reg(RegFriction, '0);
    write_reg(RegMaxSpdX, '0);
    write_reg(RegMaxSpdY, '0);
    send_tick(TickMax, q16(500), q16(-500));
    wait_idle();
  endtask

  // Radius wider than the arena, a zero-size arena, and pinning at each wall
  task automatic test_wall_pinning();
    write_reg(RegMaxSpdX, CfgDataW'(SpeedTop));
    write_reg(RegMaxSpdY, CfgDataW'(SpeedTop));
    write_reg(RegRadius, CfgDataW'(PixTop));
    write_reg(RegWidth, 32'd1);
    write_reg(RegHeight, '0);
    send_tick(16'd1000, q16(10), q16(-10));
    wait_idle();
    write_reg(RegRadius, '0);
    write_reg(RegWidth, CfgDataW'(PixTop));
    write_reg(RegHeight, 32'd1);
    send_tick(TickMax, WordMax, WordMax);
    send_tick(TickMax, WordMin, WordMin);
    send_tick(TickMax, WordMin, WordMin);
    wait_idle();
  endtask

  // Spare indexes are dropped and high data bits are masked off
  task automatic test_register_masking();
    write_reg(RegSpare6, 32'hFFFF_FFFF);
    write_reg(RegSpare7, 32'h1234_5678);
    write_reg(RegRadius, 32'hFFFF_F005);
    write_reg(RegWidth, 32'hABCD_E0FF);
    write_reg(RegHeight, 32'h8000_00C8);
    write_reg(RegFriction, 32'h8000_0000);
    write_reg(RegMaxSpdX, 32'hFFFF_FFFF);
    write_reg(RegMaxSpdY, 32'h8001_0000);
    send_tick(16'd4096, q16(700), q16(-700));
    send_tick(16'd4096, q16(-700), q16(700));
    wait_idle();
  endtask

  task automatic run_random_phase(input int unsigned gap_pct, input int unsigned stall_pct);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    repeat (RunsPerPhase) begin
      apply_random_settings();
      run_random_ticks(ItemsPerRun);
      wait_idle();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_tick_extremes();
    test_speed_saturation();
    test_friction_and_limits();
    test_wall_pinning();
    test_register_masking();

    run_random_phase(8, 66);
    run_random_phase(66, 8);
    run_random_phase(0, 0);

    // Let any stray result show up before judging
    wait_idle();
    repeat (TailCycles) @(posedge clk);

    $display("tb: %0d ticks sent, %0d results checked, %0d register writes",
             ticks_sent, results_seen, cfg_writes);
    $display("tb: %0d results pinned against a wall, %0d mismatches",
             wall_hits, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* ball_motion_step.f */
design/bms_pkg.sv
design/bms_serial_mul.sv
design/bms_axis.sv
design/ball_motion_step.sv
tb/sv/ball_motion_step_test.sv
